// ===== rtl/core/cabp_pkg.sv =====
// ----------------------------------------------------------------------------
// CIGAR aligned-block parser package
// Item types, the result bundle passed from the core and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cabp_pkg;

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_M = 8'h4D;

  localparam int unsigned STRAND_BIT = 4;

  localparam logic KIND_BLOCK = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  typedef struct packed {
    logic [7:0]  cigar_char;
    logic        first_char;
    logic        last_char;
    logic [30:0] ref_start;
    logic [11:0] sam_flags;
    logic [15:0] chrom_id;
    logic [27:0] read_length;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] block_start;
    logic [31:0] block_end;
    logic        reverse_strand;
    logic [15:0] chrom_out;
    logic        length_mismatch;
    logic [31:0] query_length;
    logic        malformed;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic      blk_vld;
    logic      chk_vld;
    out_item_t blk;
    out_item_t chk;
  } cabp_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/cabp_core.sv =====
// ----------------------------------------------------------------------------
// CIGAR parser core
// Holds the record state and works out the state update and the results of
// one character combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module cabp_core #(
  parameter int POS_WIDTH   = 32,
  parameter int COUNT_WIDTH = 28
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               step,
  input  cabp_pkg::in_item_t item,
  output cabp_pkg::cabp_res_t res
);
  import cabp_pkg::*;

  logic [POS_WIDTH-1:0]   pos_r, pos_nxt;
  logic [31:0]            qsum_r, qsum_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   strand_r, strand_nxt;
  logic [15:0]            chrom_r, chrom_nxt;
  logic [27:0]            rlen_r, rlen_nxt;
  logic                   ovf_r, ovf_nxt;

  logic [POS_WIDTH-1:0]   pos_base, pos_adv, pos_last;
  logic [31:0]            qsum_base;
  logic [COUNT_WIDTH-1:0] cnt_base;
  logic                   ovf_base;
  logic [63:0]            ref_w, cnt_w, start_w, end_w;
  logic [COUNT_WIDTH+3:0] cnt_ext, cnt_mul;
  logic [32:0]            qsum_add;
  logic                   is_digit, add_q, add_p, is_m;

  always_comb begin
    ref_w     = 64'(item.ref_start);
    pos_base  = item.first_char ? ref_w[POS_WIDTH-1:0] : pos_r;
    qsum_base = item.first_char ? 32'd0 : qsum_r;
    cnt_base  = item.first_char ? '0 : cnt_r;
    ovf_base  = item.first_char ? 1'b0 : ovf_r;
    strand_nxt = item.first_char ? item.sam_flags[STRAND_BIT] : strand_r;
    chrom_nxt  = item.first_char ? item.chrom_id : chrom_r;
    rlen_nxt   = item.first_char ? item.read_length : rlen_r;

    is_digit = (item.cigar_char >= CH_0) && (item.cigar_char <= CH_9);
    is_m     = (item.cigar_char == CH_M);
    add_q    = is_m || (item.cigar_char == CH_S) || (item.cigar_char == CH_I);
    add_p    = is_m || (item.cigar_char == CH_D) || (item.cigar_char == CH_N);

    cnt_ext = (COUNT_WIDTH+4)'(cnt_base);
    cnt_mul = (cnt_ext << 3) + (cnt_ext << 1) + (COUNT_WIDTH+4)'(item.cigar_char[3:0]);

    cnt_w    = 64'(cnt_base);
    pos_adv  = pos_base + cnt_w[POS_WIDTH-1:0];
    pos_last = pos_adv - POS_WIDTH'(1);
    qsum_add = {1'b0, qsum_base} + 33'(cnt_base);

    pos_nxt  = pos_base;
    qsum_nxt = qsum_base;
    ovf_nxt  = ovf_base;
    cnt_nxt  = '0;
    if (is_digit) begin
      if (|cnt_mul[COUNT_WIDTH+3:COUNT_WIDTH]) begin
        cnt_nxt = '1;
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_mul[COUNT_WIDTH-1:0];
      end
    end else begin
      if (add_q) begin
        if (qsum_add[32]) begin
          qsum_nxt = '1;
          ovf_nxt  = 1'b1;
        end else begin
          qsum_nxt = qsum_add[31:0];
        end
      end
      if (add_p) begin
        pos_nxt = pos_adv;
      end
    end
    if (item.last_char) begin
      cnt_nxt = '0;
    end

    start_w = 64'(pos_base);
    end_w   = 64'(pos_last);

    res.blk_vld               = is_m;
    res.blk.result_kind       = KIND_BLOCK;
    res.blk.block_start       = start_w[31:0];
    res.blk.block_end         = end_w[31:0];
    res.blk.reverse_strand    = strand_nxt;
    res.blk.chrom_out         = chrom_nxt;
    res.blk.length_mismatch   = 1'b0;
    res.blk.query_length      = qsum_nxt;
    res.blk.malformed         = ovf_nxt;
    res.blk.last_result       = !item.last_char;

    res.chk_vld               = item.last_char;
    res.chk.result_kind       = KIND_CHECK;
    res.chk.block_start       = 32'd0;
    res.chk.block_end         = 32'd0;
    res.chk.reverse_strand    = strand_nxt;
    res.chk.chrom_out         = chrom_nxt;
    res.chk.length_mismatch   = (qsum_nxt != 32'(rlen_nxt));
    res.chk.query_length      = qsum_nxt;
    res.chk.malformed         = ovf_nxt;
    res.chk.last_result       = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      qsum_r   <= '0;
      cnt_r    <= '0;
      strand_r <= 1'b0;
      chrom_r  <= '0;
      rlen_r   <= '0;
      ovf_r    <= 1'b0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      qsum_r   <= qsum_nxt;
      cnt_r    <= cnt_nxt;
      strand_r <= strand_nxt;
      chrom_r  <= chrom_nxt;
      rlen_r   <= rlen_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cigar_aligned_block_parser.sv =====
// ----------------------------------------------------------------------------
// CIGAR aligned-block parser: one character per cycle unless stalled; results pass a pending
// register, then the output register. A character giving one result sustains one item per cycle
// while out_ready is high; one giving a block and a check holds the input until the block reaches
// the single output. Synchronous active-low reset clears the record state and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cigar_aligned_block_parser #(
  parameter int POS_WIDTH   = 32,
  parameter int COUNT_WIDTH = 28
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  cabp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output cabp_pkg::out_item_t out_data
);
  import cabp_pkg::*;

  cabp_res_t res;
  logic      in_fire, o_free;

  logic      p_blk_vld_r, p_blk_vld_nxt;
  logic      p_chk_vld_r, p_chk_vld_nxt;
  out_item_t p_blk_r, p_blk_nxt;
  out_item_t p_chk_r, p_chk_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  cabp_core #(
    .POS_WIDTH  (POS_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (in_fire),
    .item (in_data),
    .res  (res)
  );

  always_comb begin
    o_free   = !out_valid_r || out_ready;
    in_ready = (!p_blk_vld_r && !p_chk_vld_r) || (o_free && !(p_blk_vld_r && p_chk_vld_r));
    in_fire  = in_valid && in_ready;

    p_blk_vld_nxt = p_blk_vld_r;
    p_chk_vld_nxt = p_chk_vld_r;
    p_blk_nxt     = p_blk_r;
    p_chk_nxt     = p_chk_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (o_free) begin
      if (p_blk_vld_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = p_blk_r;
        p_blk_vld_nxt = 1'b0;
      end else if (p_chk_vld_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = p_chk_r;
        p_chk_vld_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end

    if (in_fire) begin
      p_blk_vld_nxt = res.blk_vld;
      p_chk_vld_nxt = res.chk_vld;
      p_blk_nxt     = res.blk;
      p_chk_nxt     = res.chk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_blk_vld_r <= 1'b0;
      p_chk_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_blk_vld_r <= p_blk_vld_nxt;
      p_chk_vld_r <= p_chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_blk_r    <= p_blk_nxt;
    p_chk_r    <= p_chk_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (p_blk_vld_r && p_chk_vld_r) |-> !in_ready)
    else $error("input taken while both pending results are held");

  a_last_makes_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last_char) |=> p_chk_vld_r)
    else $error("last character did not queue a length check");

  a_check_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.result_kind == KIND_CHECK) |-> out_data_r.last_result)
    else $error("length check not marked as last result");

  a_block_followed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.result_kind == KIND_BLOCK && !out_data_r.last_result)
      |-> p_chk_vld_r)
    else $error("block expects a following check that is not queued");
`endif

endmodule

`default_nettype wire
